// File: rtl/tcci_pkg.sv
// Shared widths, constants and types for the trilinear color cell interpolator.
package tcci_pkg;

  localparam int CHANNEL_BITS  = 16;
  localparam int FRACTION_BITS = 16;

  localparam int SLOT_BITS   = 16;
  localparam int NUM_CH      = 3;
  localparam int NUM_CORNERS = 8;
  localparam int COORD_BITS  = 16;
  localparam int BOUND_BITS  = 8;

  // Divider retires this many quotient bits per pipeline stage.
  localparam int DIV_STEPS  = 4;
  localparam int DIV_STAGES = (FRACTION_BITS + DIV_STEPS - 1) / DIV_STEPS;
  // Prep register plus divider stages.
  localparam int DIV_LAT    = DIV_STAGES + 1;
  // Three lerp levels follow the divider.
  localparam int LAT        = DIV_LAT + 3;

  typedef logic [CHANNEL_BITS-1:0]  chan_t;
  typedef logic [FRACTION_BITS:0]   frac_t;
  typedef logic [NUM_CORNERS-1:0][NUM_CH-1:0][CHANNEL_BITS-1:0] corners_t;

endpackage

// File: rtl/tcci_if.sv
// Valid/ready channel interfaces for the interpolator input and result words.
interface tcci_in_if;
  logic        valid;
  logic        ready;
  logic [47:0] point_coords;
  logic [23:0] low_bounds;
  logic [23:0] high_bounds;
  logic [47:0] corner_000;
  logic [47:0] corner_001;
  logic [47:0] corner_010;
  logic [47:0] corner_011;
  logic [47:0] corner_100;
  logic [47:0] corner_101;
  logic [47:0] corner_110;
  logic [47:0] corner_111;

  modport source (
    output valid, point_coords, low_bounds, high_bounds,
    output corner_000, corner_001, corner_010, corner_011,
    output corner_100, corner_101, corner_110, corner_111,
    input  ready
  );
  modport sink (
    input  valid, point_coords, low_bounds, high_bounds,
    input  corner_000, corner_001, corner_010, corner_011,
    input  corner_100, corner_101, corner_110, corner_111,
    output ready
  );
endinterface

interface tcci_out_if;
  logic        valid;
  logic        ready;
  logic [47:0] out_color;
  logic        degenerate_cell;

  modport source (output valid, out_color, degenerate_cell, input ready);
  modport sink   (input valid, out_color, degenerate_cell, output ready);
endinterface

// File: rtl/tcci_axis_div.sv
// Per-axis fraction: span checks, then a pipelined restoring divider.
module tcci_axis_div (
  input  logic                              clk,
  input  logic                              en,
  input  logic [tcci_pkg::COORD_BITS-1:0]   coord,
  input  logic [tcci_pkg::BOUND_BITS-1:0]   lo,
  input  logic [tcci_pkg::BOUND_BITS-1:0]   hi,
  output tcci_pkg::frac_t                   frac,
  output logic                              degen
);
  import tcci_pkg::*;

  localparam int SPAN_BITS = COORD_BITS;
  localparam int FRAC_W    = FRACTION_BITS;

  logic [SPAN_BITS-1:0] span_r  [DIV_STAGES+1];
  logic [SPAN_BITS-1:0] rem_r   [DIV_STAGES+1];
  logic [FRAC_W-1:0]    quo_r   [DIV_STAGES+1];
  logic                 zero_r  [DIV_STAGES+1];
  logic                 one_r   [DIV_STAGES+1];
  logic                 degen_r [DIV_STAGES+1];

  logic [SPAN_BITS-1:0] base, span, num;
  logic                 is_degen, is_zero, is_one;

  always_comb begin
    is_degen = (hi <= lo);
    base     = {lo, {(SPAN_BITS-BOUND_BITS){1'b0}}};
    span     = {hi - lo, {(SPAN_BITS-BOUND_BITS){1'b0}}};
    num      = coord - base;
    is_zero  = is_degen || (coord <= base);
    is_one   = !is_zero && (num >= span);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      span_r[0]  <= span;
      rem_r[0]   <= num;
      quo_r[0]   <= '0;
      zero_r[0]  <= is_zero;
      one_r[0]   <= is_one;
      degen_r[0] <= is_degen;
    end
  end

  for (genvar s = 1; s <= DIV_STAGES; s++) begin : g_stage
    logic [SPAN_BITS-1:0] rem_nxt;
    logic [FRAC_W-1:0]    quo_nxt;
    logic [SPAN_BITS:0]   trial;

    // Remainder stays below span, so each step fits one extra bit.
    always_comb begin
      rem_nxt = rem_r[s-1];
      quo_nxt = quo_r[s-1];
      trial   = '0;
      for (int j = 0; j < DIV_STEPS; j++) begin
        if ((s-1)*DIV_STEPS + j < FRAC_W) begin
          trial = {rem_nxt, 1'b0};
          if (trial >= {1'b0, span_r[s-1]}) begin
            rem_nxt = SPAN_BITS'(trial - {1'b0, span_r[s-1]});
            quo_nxt = {quo_nxt[FRAC_W-2:0], 1'b1};
          end else begin
            rem_nxt = trial[SPAN_BITS-1:0];
            quo_nxt = {quo_nxt[FRAC_W-2:0], 1'b0};
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        span_r[s]  <= span_r[s-1];
        rem_r[s]   <= rem_nxt;
        quo_r[s]   <= quo_nxt;
        zero_r[s]  <= zero_r[s-1];
        one_r[s]   <= one_r[s-1];
        degen_r[s] <= degen_r[s-1];
      end
    end
  end

  always_comb begin
    if (zero_r[DIV_STAGES]) begin
      frac = '0;
    end else if (one_r[DIV_STAGES]) begin
      frac = {1'b1, {FRAC_W{1'b0}}};
    end else begin
      frac = {1'b0, quo_r[DIV_STAGES]};
    end
    degen = degen_r[DIV_STAGES];
  end

endmodule

// File: rtl/tcci_blend.sv
// One registered linear blend a + (b - a) * f with round-half-up.
module tcci_blend (
  input  logic            clk,
  input  logic            en,
  input  tcci_pkg::chan_t a,
  input  tcci_pkg::chan_t b,
  input  tcci_pkg::frac_t f,
  output tcci_pkg::chan_t y_r
);
  import tcci_pkg::*;

  localparam int ACC_W = CHANNEL_BITS + FRACTION_BITS + 3;

  logic signed [CHANNEL_BITS:0]    diff;
  logic signed [FRACTION_BITS+1:0] fs;
  logic signed [ACC_W-1:0]         prod;
  logic signed [ACC_W-1:0]         acc;
  chan_t                           y_nxt;

  always_comb begin
    diff  = $signed({1'b0, b}) - $signed({1'b0, a});
    fs    = $signed({1'b0, f});
    prod  = diff * fs;
    acc   = $signed({3'b000, a, {FRACTION_BITS{1'b0}}}) + prod
          + $signed(ACC_W'(1) <<< (FRACTION_BITS - 1));
    y_nxt = acc[FRACTION_BITS +: CHANNEL_BITS];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      y_r <= y_nxt;
    end
  end

endmodule

// File: rtl/trilinear_color_cell_interpolator_unit.sv
// Trilinear color cell interpolator: three axis dividers feeding x, y, z blend levels.
// One word per cycle sustained while the output word is taken.
// Throughput is set by the fully pipelined divider (4 quotient bits per stage).
// The whole pipeline holds when the output word is not taken.
// rst_n (synchronous) clears the valid bits only; data registers are not reset.
module trilinear_color_cell_interpolator_unit (
  input  logic   clk,
  input  logic   rst_n,
  tcci_in_if.sink    in_ch,
  tcci_out_if.source out_ch
);
  import tcci_pkg::*;

  logic          en;
  logic [LAT-1:0] vld_r;
  corners_t      cor_in;
  corners_t      cor_r [DIV_LAT];
  frac_t         fx, fy, fz;
  logic          dgx, dgy, dgz;
  logic [2:0]    deg_r;
  chan_t         lx [4][NUM_CH];
  chan_t         ly [2][NUM_CH];
  chan_t         lz [NUM_CH];

  assign en          = !vld_r[LAT-1] || out_ch.ready;
  assign in_ch.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_ch.valid};
    end
  end

  always_comb begin
    logic [47:0] c [NUM_CORNERS];
    c[0] = in_ch.corner_000;
    c[1] = in_ch.corner_001;
    c[2] = in_ch.corner_010;
    c[3] = in_ch.corner_011;
    c[4] = in_ch.corner_100;
    c[5] = in_ch.corner_101;
    c[6] = in_ch.corner_110;
    c[7] = in_ch.corner_111;
    for (int k = 0; k < NUM_CORNERS; k++) begin
      for (int ch = 0; ch < NUM_CH; ch++) begin
        cor_in[k][ch] = c[k][(NUM_CH-1-ch)*SLOT_BITS +: CHANNEL_BITS];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cor_r[0] <= cor_in;
      for (int s = 1; s < DIV_LAT; s++) begin
        cor_r[s] <= cor_r[s-1];
      end
      deg_r <= {deg_r[1:0], dgx | dgy | dgz};
    end
  end

  tcci_axis_div u_div_x (
    .clk, .en, .coord(in_ch.point_coords[47:32]),
    .lo(in_ch.low_bounds[23:16]), .hi(in_ch.high_bounds[23:16]), .frac(fx), .degen(dgx)
  );
  tcci_axis_div u_div_y (
    .clk, .en, .coord(in_ch.point_coords[31:16]),
    .lo(in_ch.low_bounds[15:8]), .hi(in_ch.high_bounds[15:8]), .frac(fy), .degen(dgy)
  );
  tcci_axis_div u_div_z (
    .clk, .en, .coord(in_ch.point_coords[15:0]),
    .lo(in_ch.low_bounds[7:0]), .hi(in_ch.high_bounds[7:0]), .frac(fz), .degen(dgz)
  );

  // Fractions for y and z are needed one and two levels later.
  frac_t fy_r, fz_r, fz_rr;
  always_ff @(posedge clk) begin
    if (en) begin
      fy_r  <= fy;
      fz_r  <= fz;
      fz_rr <= fz_r;
    end
  end

  for (genvar ch = 0; ch < NUM_CH; ch++) begin : g_ch
    // x level: corner index bit 2 is x, so pair k with k + 4.
    for (genvar k = 0; k < 4; k++) begin : g_x
      tcci_blend u_bx (
        .clk, .en, .a(cor_r[DIV_LAT-1][k][ch]), .b(cor_r[DIV_LAT-1][k+4][ch]),
        .f(fx), .y_r(lx[k][ch])
      );
    end
    for (genvar k = 0; k < 2; k++) begin : g_y
      tcci_blend u_by (
        .clk, .en, .a(lx[k][ch]), .b(lx[k+2][ch]), .f(fy_r), .y_r(ly[k][ch])
      );
    end
    tcci_blend u_bz (
      .clk, .en, .a(ly[0][ch]), .b(ly[1][ch]), .f(fz_rr), .y_r(lz[ch])
    );
    assign out_ch.out_color[(NUM_CH-1-ch)*SLOT_BITS +: SLOT_BITS] =
      SLOT_BITS'(lz[ch]);
  end

  assign out_ch.valid           = vld_r[LAT-1];
  assign out_ch.degenerate_cell = deg_r[2];

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_ch.valid)
    else $error("result valid right after reset");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |-> !in_ch.ready)
    else $error("input taken while the result word is stalled");

  a_ready_drop_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(in_ch.ready) |-> out_ch.valid)
    else $error("input ready dropped with no result pending");

  a_stall_holds_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(vld_r))
    else $error("pipeline valid bits moved during a stall");

endmodule
